[rtl/i2cbb_pkg.sv]
// Shared types and constants for the I2C bit-bang master.
// Holds the command and phase encodings and the structs passed between stages.
// No dependencies.
`timescale 1ns / 1ps

package i2cbb_pkg;

    // width of the delay unit tick counter
    localparam int DIVIDER_WIDTH = 16;

    // delay unit register width and reset value
    localparam int DELAY_WIDTH = 16;
    localparam logic [DELAY_WIDTH-1:0] DELAY_RESET = 16'd48;

    // bits per transferred byte
    localparam int BYTE_BITS = 8;

    // stream widths
    localparam int S_TDATA_WIDTH = 16;
    localparam int M_TDATA_WIDTH = 16;

    // command codes
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // bus sequence phases
    typedef enum logic [4:0] {
        PH_IDLE   = 5'd0,
        PH_ST_A1  = 5'd1,
        PH_ST_A2  = 5'd2,
        PH_ST_B1  = 5'd3,
        PH_ST_B2  = 5'd4,
        PH_SP_A   = 5'd5,
        PH_SP_B   = 5'd6,
        PH_SP_C   = 5'd7,
        PH_WR_A   = 5'd8,
        PH_WR_B   = 5'd9,
        PH_WR_BIT = 5'd10,
        PH_WR_ACK = 5'd11,
        PH_RD_LO  = 5'd12,
        PH_RD_HI  = 5'd13,
        PH_RA_A   = 5'd14,
        PH_RA_B   = 5'd15,
        PH_RA_C1  = 5'd16,
        PH_RA_C2  = 5'd17,
        PH_RA_D   = 5'd18,
        PH_RN_A   = 5'd19,
        PH_RN_B   = 5'd20,
        PH_RN_C1  = 5'd21,
        PH_RN_C2  = 5'd22
    } phase_t;

    // one input tick
    typedef struct packed {
        logic       sda_in;
        logic       send_ack;
        logic [7:0] tx_byte;
        op_t        operation;
        logic       cmd_valid;
    } cmd_t;

    // one result tick
    typedef struct packed {
        logic       ack_seen;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_level;
        logic       sda_drive_enable;
        logic       scl_level;
    } result_t;

endpackage

[rtl/i2cbb_in_stage.sv]
// Input register of the I2C bit-bang master.
// Takes one tick transaction from the slave stream and holds it for the engine.
// Depends on i2cbb_pkg.
`timescale 1ns / 1ps

module i2cbb_in_stage (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [0] cmd_valid, [2:1] operation, [10:3] tx_byte, [11] send_ack, [12] sda_in
    input  logic [i2cbb_pkg::S_TDATA_WIDTH-1:0]    s_tdata,
    input  logic                                   fire,
    output logic                                   in_valid,
    output i2cbb_pkg::cmd_t                        cmd
);

    logic             valid_reg;
    logic             valid_next;
    i2cbb_pkg::cmd_t  cmd_reg;
    i2cbb_pkg::cmd_t  cmd_next;
    logic             load;

    // slot frees when the engine consumes it
    assign s_tready = !valid_reg || fire;
    assign load     = s_tvalid && s_tready;

    // unpack and hold
    always_comb
    begin
        cmd_next = cmd_reg;
        if (load)
        begin
            cmd_next.cmd_valid = s_tdata[0];
            cmd_next.operation = i2cbb_pkg::op_t'(s_tdata[2:1]);
            cmd_next.tx_byte   = s_tdata[10:3];
            cmd_next.send_ack  = s_tdata[11];
            cmd_next.sda_in    = s_tdata[12];
        end
        valid_next = load ? 1'b1 : (fire ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign in_valid = valid_reg;
    assign cmd      = cmd_reg;

endmodule

[rtl/i2cbb_engine.sv]
// Bus sequencer of the I2C bit-bang master: phase machine, delay counter and
// shift datapath, advanced by one tick per consumed transaction.
// Depends on i2cbb_pkg.
`timescale 1ns / 1ps

module i2cbb_engine (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [i2cbb_pkg::DELAY_WIDTH-1:0]     cfg_wdata,
    input  logic                                  fire,
    input  i2cbb_pkg::cmd_t                       cmd,
    output i2cbb_pkg::result_t                    result
);

    localparam int DivW = i2cbb_pkg::DIVIDER_WIDTH;
    localparam int DlyW = i2cbb_pkg::DELAY_WIDTH;

    i2cbb_pkg::phase_t  phase_reg;
    i2cbb_pkg::phase_t  phase_next;
    logic [DlyW-1:0]    delay_reg;
    logic [DivW-1:0]    tick_reg;
    logic [DivW-1:0]    tick_next;
    logic [DivW-1:0]    tick_load;
    logic [DlyW-1:0]    unit;
    logic [3:0]         bit_reg;
    logic [3:0]         bit_next;
    logic [3:0]         bit_inc;
    logic [7:0]         shift_reg;
    logic [7:0]         shift_next;
    logic               ack_choice_reg;
    logic               ack_choice_next;
    logic               scl_reg;
    logic               scl_next;
    logic               sda_oe_reg;
    logic               sda_oe_next;
    logic               sda_out_reg;
    logic               sda_out_next;
    logic               ack_reg;
    logic               ack_next;
    logic [7:0]         rx_reg;
    logic [7:0]         rx_next;
    logic               enter_en;
    logic               done;
    logic               tick_zero;

    // a zero delay unit behaves as one tick
    assign unit      = (delay_reg == '0) ? DlyW'(1) : delay_reg;
    assign tick_load = DivW'(unit - DlyW'(1));
    assign tick_zero = (tick_reg == '0);
    assign bit_inc   = bit_reg + 4'd1;

    // next phase, step entry and completion
    always_comb
    begin
        phase_next = phase_reg;
        enter_en   = 1'b0;
        done       = 1'b0;
        if (fire)
        begin
            if (phase_reg == i2cbb_pkg::PH_IDLE)
            begin
                if (cmd.cmd_valid)
                begin
                    enter_en = 1'b1;
                    case (cmd.operation)
                        i2cbb_pkg::OP_START: phase_next = i2cbb_pkg::PH_ST_A1;
                        i2cbb_pkg::OP_STOP:  phase_next = i2cbb_pkg::PH_SP_A;
                        i2cbb_pkg::OP_WRITE: phase_next = i2cbb_pkg::PH_WR_A;
                        default:             phase_next = i2cbb_pkg::PH_RD_LO;
                    endcase
                end
            end
            else if (tick_zero)
            begin
                enter_en = 1'b1;
                case (phase_reg)
                    i2cbb_pkg::PH_ST_A1: phase_next = i2cbb_pkg::PH_ST_A2;
                    i2cbb_pkg::PH_ST_A2: phase_next = i2cbb_pkg::PH_ST_B1;
                    i2cbb_pkg::PH_ST_B1: phase_next = i2cbb_pkg::PH_ST_B2;
                    i2cbb_pkg::PH_SP_A:  phase_next = i2cbb_pkg::PH_SP_B;
                    i2cbb_pkg::PH_SP_B:  phase_next = i2cbb_pkg::PH_SP_C;
                    i2cbb_pkg::PH_WR_A:  phase_next = i2cbb_pkg::PH_WR_B;
                    i2cbb_pkg::PH_WR_B:  phase_next = i2cbb_pkg::PH_WR_BIT;
                    i2cbb_pkg::PH_WR_BIT:
                    begin
                        phase_next = (bit_inc < 4'(i2cbb_pkg::BYTE_BITS))
                                   ? i2cbb_pkg::PH_WR_BIT : i2cbb_pkg::PH_WR_ACK;
                    end
                    i2cbb_pkg::PH_RD_LO: phase_next = i2cbb_pkg::PH_RD_HI;
                    i2cbb_pkg::PH_RD_HI:
                    begin
                        if (bit_inc < 4'(i2cbb_pkg::BYTE_BITS))
                        begin
                            phase_next = i2cbb_pkg::PH_RD_LO;
                        end
                        else
                        begin
                            phase_next = ack_choice_reg ? i2cbb_pkg::PH_RA_A
                                                        : i2cbb_pkg::PH_RN_A;
                        end
                    end
                    i2cbb_pkg::PH_RA_A:  phase_next = i2cbb_pkg::PH_RA_B;
                    i2cbb_pkg::PH_RA_B:  phase_next = i2cbb_pkg::PH_RA_C1;
                    i2cbb_pkg::PH_RA_C1: phase_next = i2cbb_pkg::PH_RA_C2;
                    i2cbb_pkg::PH_RA_C2: phase_next = i2cbb_pkg::PH_RA_D;
                    i2cbb_pkg::PH_RN_A:  phase_next = i2cbb_pkg::PH_RN_B;
                    i2cbb_pkg::PH_RN_B:  phase_next = i2cbb_pkg::PH_RN_C1;
                    i2cbb_pkg::PH_RN_C1: phase_next = i2cbb_pkg::PH_RN_C2;
                    // last step of a sequence
                    default:
                    begin
                        phase_next = i2cbb_pkg::PH_IDLE;
                        enter_en   = 1'b0;
                        done       = 1'b1;
                    end
                endcase
            end
        end
    end

    // line levels, counters and shift register
    always_comb
    begin
        tick_next       = tick_reg;
        bit_next        = bit_reg;
        shift_next      = shift_reg;
        ack_choice_next = ack_choice_reg;
        scl_next        = scl_reg;
        sda_oe_next     = sda_oe_reg;
        sda_out_next    = sda_out_reg;
        ack_next        = ack_reg;
        rx_next         = rx_reg;
        if (fire)
        begin
            // command pickup, countdown, or end-of-step actions
            if (phase_reg == i2cbb_pkg::PH_IDLE)
            begin
                if (cmd.cmd_valid)
                begin
                    bit_next = '0;
                    if (cmd.operation == i2cbb_pkg::OP_WRITE)
                    begin
                        shift_next = cmd.tx_byte;
                    end
                    else if (cmd.operation == i2cbb_pkg::OP_READ)
                    begin
                        ack_choice_next = cmd.send_ack;
                        shift_next      = '0;
                        sda_oe_next     = 1'b0;
                    end
                end
            end
            else if (!tick_zero)
            begin
                tick_next = tick_reg - DivW'(1);
            end
            else
            begin
                tick_next = '0;
                case (phase_reg)
                    i2cbb_pkg::PH_ST_B2:  scl_next = 1'b0;
                    i2cbb_pkg::PH_SP_C:   sda_out_next = 1'b1;
                    i2cbb_pkg::PH_WR_BIT:
                    begin
                        scl_next = 1'b0;
                        bit_next = bit_inc;
                    end
                    i2cbb_pkg::PH_WR_ACK:
                    begin
                        ack_next = !cmd.sda_in;
                        scl_next = 1'b0;
                    end
                    i2cbb_pkg::PH_RD_HI:
                    begin
                        shift_next = {shift_reg[6:0], cmd.sda_in};
                        bit_next   = bit_inc;
                        if (bit_inc >= 4'(i2cbb_pkg::BYTE_BITS))
                        begin
                            rx_next = {shift_reg[6:0], cmd.sda_in};
                        end
                    end
                    i2cbb_pkg::PH_RA_D:   scl_next = 1'b0;
                    default:              ;
                endcase
            end

            // levels set on entry to a step
            if (enter_en)
            begin
                tick_next = tick_load;
                case (phase_next)
                    i2cbb_pkg::PH_ST_A1:
                    begin
                        sda_oe_next  = 1'b1;
                        sda_out_next = 1'b1;
                        scl_next     = 1'b1;
                    end
                    i2cbb_pkg::PH_ST_B1:  sda_out_next = 1'b0;
                    i2cbb_pkg::PH_SP_A:
                    begin
                        sda_oe_next = 1'b1;
                        scl_next    = 1'b0;
                    end
                    i2cbb_pkg::PH_SP_B:   sda_out_next = 1'b0;
                    i2cbb_pkg::PH_SP_C:   scl_next = 1'b1;
                    i2cbb_pkg::PH_WR_A:   scl_next = 1'b0;
                    i2cbb_pkg::PH_WR_B:   sda_oe_next = 1'b1;
                    i2cbb_pkg::PH_WR_BIT:
                    begin
                        sda_out_next = shift_next[7];
                        shift_next   = {shift_next[6:0], 1'b0};
                        scl_next     = 1'b1;
                    end
                    i2cbb_pkg::PH_WR_ACK:
                    begin
                        sda_oe_next = 1'b0;
                        scl_next    = 1'b1;
                    end
                    i2cbb_pkg::PH_RD_LO:  scl_next = 1'b0;
                    i2cbb_pkg::PH_RD_HI:  scl_next = 1'b1;
                    i2cbb_pkg::PH_RA_A:   scl_next = 1'b0;
                    i2cbb_pkg::PH_RA_B:
                    begin
                        sda_oe_next  = 1'b1;
                        sda_out_next = 1'b0;
                    end
                    i2cbb_pkg::PH_RA_C1:  scl_next = 1'b1;
                    i2cbb_pkg::PH_RA_D:   scl_next = 1'b0;
                    i2cbb_pkg::PH_RN_A:   scl_next = 1'b0;
                    i2cbb_pkg::PH_RN_B:   sda_oe_next = 1'b0;
                    i2cbb_pkg::PH_RN_C1:  scl_next = 1'b1;
                    default:              ;
                endcase
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= i2cbb_pkg::PH_IDLE;
            delay_reg      <= i2cbb_pkg::DELAY_RESET;
            tick_reg       <= '0;
            bit_reg        <= '0;
            shift_reg      <= '0;
            ack_choice_reg <= 1'b0;
            scl_reg        <= 1'b1;
            sda_oe_reg     <= 1'b0;
            sda_out_reg    <= 1'b1;
            ack_reg        <= 1'b0;
            rx_reg         <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            if (cfg_we)
            begin
                delay_reg  <= cfg_wdata;
            end
            tick_reg       <= tick_next;
            bit_reg        <= bit_next;
            shift_reg      <= shift_next;
            ack_choice_reg <= ack_choice_next;
            scl_reg        <= scl_next;
            sda_oe_reg     <= sda_oe_next;
            sda_out_reg    <= sda_out_next;
            ack_reg        <= ack_next;
            rx_reg         <= rx_next;
        end
    end

    // result of this tick, taken by the output register
    always_comb
    begin
        result.scl_level        = scl_next;
        result.sda_drive_enable = sda_oe_next;
        result.sda_level        = sda_out_next;
        result.busy_res         = (phase_next != i2cbb_pkg::PH_IDLE);
        result.done_res         = done;
        result.rx_byte          = rx_next;
        result.ack_seen         = ack_next;
    end

    // completion always returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (phase_next == i2cbb_pkg::PH_IDLE))
        else $error("sequence completed without returning to idle");

    // bit counter never runs past one byte
    assert property (@(posedge clk) disable iff (!rst_n)
        bit_reg <= 4'(i2cbb_pkg::BYTE_BITS))
        else $error("bit counter overran a byte");

    // idle leaves the delay counter cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == i2cbb_pkg::PH_IDLE) |-> tick_zero)
        else $error("delay counter nonzero while idle");

    // a step holds its phase while the delay counter runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (phase_reg != i2cbb_pkg::PH_IDLE) && !tick_zero)
        |=> (phase_reg == $past(phase_reg)))
        else $error("phase changed before its delay expired");

    // no phase change without a consumed transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(phase_reg))
        else $error("phase moved without a transaction");

endmodule

[rtl/i2cbb_out_stage.sv]
// Result register of the I2C bit-bang master.
// Holds one finished result for the master stream while the engine runs on.
// Depends on i2cbb_pkg.
`timescale 1ns / 1ps

module i2cbb_out_stage (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  fire,
    input  i2cbb_pkg::result_t                    result,
    output logic                                  take,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [0] scl_level, [1] sda_drive_enable, [2] sda_level, [3] busy_res,
    // [4] done_res, [12:5] rx_byte, [13] ack_seen
    output logic [i2cbb_pkg::M_TDATA_WIDTH-1:0]   m_tdata
);

    logic                valid_reg;
    logic                valid_next;
    i2cbb_pkg::result_t  res_reg;
    i2cbb_pkg::result_t  res_next;

    // room for a new result when empty or being drained
    assign take = !valid_reg || m_tready;

    always_comb
    begin
        res_next   = fire ? result : res_reg;
        valid_next = fire ? 1'b1 : (m_tready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // pack the result onto the stream
    assign m_tvalid = valid_reg;
    always_comb
    begin
        m_tdata        = '0;
        m_tdata[0]     = res_reg.scl_level;
        m_tdata[1]     = res_reg.sda_drive_enable;
        m_tdata[2]     = res_reg.sda_level;
        m_tdata[3]     = res_reg.busy_res;
        m_tdata[4]     = res_reg.done_res;
        m_tdata[12:5]  = res_reg.rx_byte;
        m_tdata[13]    = res_reg.ack_seen;
    end

endmodule

[rtl/i2c_bit_bang_master.sv]
// I2C bit-bang master top level: input register, bus sequencer, result register.
// Depends on i2cbb_pkg, i2cbb_in_stage, i2cbb_engine and i2cbb_out_stage.
`timescale 1ns / 1ps

// Every transaction on the slave stream is one tick of the bus timing base and
// yields exactly one transaction on the master stream carrying the line levels,
// busy and done flags, last received byte and last acknowledge after that tick.
// The block takes one tick per clock cycle when the master stream is not
// stalled; an accepted tick is held in the input register, and its result,
// computed by the sequencer logic, is held in the result register for the
// master stream. Stalls on the master stream hold the sequencer and, once the
// input register is full, lower s_tready. A bus step lasts delay_unit_ticks
// ticks (zero counts as one); a command offered while a sequence runs, or on
// its final tick, is dropped.
// Write cfg_wdata with cfg_we only while no sequence is running.

module i2c_bit_bang_master (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [i2cbb_pkg::DELAY_WIDTH-1:0]     cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [0] cmd_valid, [2:1] operation, [10:3] tx_byte, [11] send_ack, [12] sda_in
    input  logic [i2cbb_pkg::S_TDATA_WIDTH-1:0]   s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [0] scl_level, [1] sda_drive_enable, [2] sda_level, [3] busy_res,
    // [4] done_res, [12:5] rx_byte, [13] ack_seen
    output logic [i2cbb_pkg::M_TDATA_WIDTH-1:0]   m_tdata
);

    logic                in_valid;
    logic                take;
    logic                fire;
    i2cbb_pkg::cmd_t     cmd;
    i2cbb_pkg::result_t  result;

    // sequencer advances when a tick is held and the result slot is free
    assign fire = in_valid && take;

    i2cbb_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .fire     (fire),
        .in_valid (in_valid),
        .cmd      (cmd)
    );

    i2cbb_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .cmd       (cmd),
        .result    (result)
    );

    i2cbb_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .result   (result),
        .take     (take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[test/i2c_bit_bang_master_tb.sv]
// Self-checking testbench for the I2C bit-bang master.
// Checks each result tick against a bus sequencer model or a hand-written word.
// Depends on i2cbb_pkg and i2c_bit_bang_master.
`timescale 1ns / 1ps

module i2c_bit_bang_master_tb;

    import i2cbb_pkg::*;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int PRESSURE_AT      = 400;
    localparam int PRESSURE_CYCLES  = 400;
    localparam int SETTLE_CYCLES    = 8;
    localparam int RANDOM_PER_PHASE = 90;
    localparam int RANDOM_PHASES    = 4;
    localparam int RES_BITS         = $bits(result_t);
    localparam int DIR_ROWS         = 22;

    // slave behavior on SDA while a sequence runs
    typedef enum logic [1:0] {
        LINE_LOW,
        LINE_HIGH,
        LINE_RAND
    } line_t;

    typedef struct {
        int unsigned unit;
        logic        valid;
        op_t         op;
        logic [7:0]  tx;
        logic        ack;
        line_t       line;
        logic        chatter;
        logic        typed;
        logic [15:0] typed_word;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [DELAY_WIDTH-1:0] cfg_wdata;
    logic s_tvalid;
    logic s_tready;
    // [0] cmd_valid, [2:1] operation, [10:3] tx_byte, [11] send_ack, [12] sda_in
    logic [S_TDATA_WIDTH-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    // [0] scl_level, [1] sda_drive_enable, [2] sda_level, [3] busy_res,
    // [4] done_res, [12:5] rx_byte, [13] ack_seen
    logic [M_TDATA_WIDTH-1:0] m_tdata;

    // bus model state
    logic [DELAY_WIDTH-1:0]   unit_cfg = DELAY_RESET;
    phase_t                   bus_phase = PH_IDLE;
    logic [DIVIDER_WIDTH-1:0] step_left = '0;
    logic [3:0]               bits_done = '0;
    logic [7:0]               shifter = '0;
    logic                     ack_pick = 1'b0;
    logic                     scl_q = 1'b1;
    logic                     oe_q = 1'b0;
    logic                     sdo_q = 1'b1;
    logic                     ack_q = 1'b0;
    logic [7:0]               rx_q = '0;

    result_t pending_lines[$];
    bit      gaps_on = 1'b1;
    int      mismatches = 0;
    int      results_seen = 0;
    int      ticks_sent = 0;
    int      sequences_done = 0;
    int      commands_dropped = 0;
    int      cfg_writes = 0;

    // directed commands, each run to completion before the next
    plan_row_t dir_plan [DIR_ROWS] = '{
        '{48,    1'b0, OP_START, 8'h00, 1'b0, LINE_HIGH, 1'b0, 1'b1, 16'h0005},
        '{48,    1'b1, OP_START, 8'h00, 1'b0, LINE_HIGH, 1'b0, 1'b1, 16'h000F},
        '{1,     1'b1, OP_WRITE, 8'hFF, 1'b0, LINE_LOW,  1'b0, 1'b0, 16'h0000},
        '{1,     1'b1, OP_WRITE, 8'h00, 1'b0, LINE_HIGH, 1'b0, 1'b0, 16'h0000},
        '{1,     1'b1, OP_WRITE, 8'hA5, 1'b1, LINE_RAND, 1'b1, 1'b0, 16'h0000},
        '{1,     1'b1, OP_READ,  8'h00, 1'b1, LINE_HIGH, 1'b0, 1'b0, 16'h0000},
        '{1,     1'b1, OP_READ,  8'hFF, 1'b0, LINE_LOW,  1'b0, 1'b0, 16'h0000},
        '{1,     1'b1, OP_READ,  8'h5A, 1'b1, LINE_RAND, 1'b1, 1'b0, 16'h0000},
        '{1,     1'b1, OP_STOP,  8'h00, 1'b0, LINE_RAND, 1'b0, 1'b0, 16'h0000},
        '{0,     1'b1, OP_START, 8'h00, 1'b0, LINE_RAND, 1'b0, 1'b0, 16'h0000},
        '{0,     1'b1, OP_WRITE, 8'h3C, 1'b0, LINE_LOW,  1'b1, 1'b0, 16'h0000},
        '{0,     1'b1, OP_READ,  8'hC3, 1'b0, LINE_RAND, 1'b1, 1'b0, 16'h0000},
        '{0,     1'b1, OP_STOP,  8'h00, 1'b1, LINE_HIGH, 1'b1, 1'b0, 16'h0000},
        '{2,     1'b1, OP_START, 8'h00, 1'b0, LINE_RAND, 1'b1, 1'b0, 16'h0000},
        '{2,     1'b1, OP_WRITE, 8'h81, 1'b1, LINE_RAND, 1'b0, 1'b0, 16'h0000},
        '{2,     1'b1, OP_READ,  8'h7E, 1'b1, LINE_RAND, 1'b0, 1'b0, 16'h0000},
        '{2,     1'b1, OP_STOP,  8'hFF, 1'b1, LINE_LOW,  1'b0, 1'b0, 16'h0000},
        '{64,    1'b1, OP_STOP,  8'h00, 1'b0, LINE_HIGH, 1'b0, 1'b0, 16'h0000},
        '{3,     1'b1, OP_START, 8'h00, 1'b0, LINE_RAND, 1'b1, 1'b0, 16'h0000},
        '{3,     1'b1, OP_WRITE, 8'hFF, 1'b1, LINE_HIGH, 1'b1, 1'b0, 16'h0000},
        '{3,     1'b1, OP_READ,  8'h00, 1'b0, LINE_LOW,  1'b0, 1'b0, 16'h0000},
        '{3,     1'b1, OP_STOP,  8'h00, 1'b0, LINE_RAND, 1'b0, 1'b0, 16'h0000}
    };

    i2c_bit_bang_master u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // start a bus step: set its line levels and load the unit count
    function automatic void begin_step(input phase_t p);
        logic [DELAY_WIDTH-1:0] u;
        u = (unit_cfg == '0) ? DELAY_WIDTH'(1) : unit_cfg;
        bus_phase = p;
        step_left = u - 1'b1;
        case (p)
            PH_ST_A1:
            begin
                oe_q = 1'b1;
                sdo_q = 1'b1;
                scl_q = 1'b1;
            end
            PH_ST_B1:  sdo_q = 1'b0;
            PH_SP_A:
            begin
                oe_q = 1'b1;
                scl_q = 1'b0;
            end
            PH_SP_B:   sdo_q = 1'b0;
            PH_SP_C:   scl_q = 1'b1;
            PH_WR_A:   scl_q = 1'b0;
            PH_WR_B:   oe_q = 1'b1;
            PH_WR_BIT:
            begin
                sdo_q = shifter[7];
                shifter = {shifter[6:0], 1'b0};
                scl_q = 1'b1;
            end
            PH_WR_ACK:
            begin
                oe_q = 1'b0;
                scl_q = 1'b1;
            end
            PH_RD_LO:  scl_q = 1'b0;
            PH_RD_HI:  scl_q = 1'b1;
            PH_RA_A:   scl_q = 1'b0;
            PH_RA_B:
            begin
                oe_q = 1'b1;
                sdo_q = 1'b0;
            end
            PH_RA_C1:  scl_q = 1'b1;
            PH_RA_D:   scl_q = 1'b0;
            PH_RN_A:   scl_q = 1'b0;
            PH_RN_B:   oe_q = 1'b0;
            PH_RN_C1:  scl_q = 1'b1;
            default:   ;
        endcase
    endfunction

    // end of the current step, returns 1 when the whole sequence is over
    function automatic logic end_step(input logic sda);
        case (bus_phase)
            PH_ST_A1:  begin begin_step(PH_ST_A2); return 1'b0; end
            PH_ST_A2:  begin begin_step(PH_ST_B1); return 1'b0; end
            PH_ST_B1:  begin begin_step(PH_ST_B2); return 1'b0; end
            PH_ST_B2:  scl_q = 1'b0;
            PH_SP_A:   begin begin_step(PH_SP_B); return 1'b0; end
            PH_SP_B:   begin begin_step(PH_SP_C); return 1'b0; end
            PH_SP_C:   sdo_q = 1'b1;
            PH_WR_A:   begin begin_step(PH_WR_B); return 1'b0; end
            PH_WR_B:   begin begin_step(PH_WR_BIT); return 1'b0; end
            PH_WR_BIT:
            begin
                scl_q = 1'b0;
                bits_done = bits_done + 1'b1;
                if (bits_done < BYTE_BITS)
                    begin_step(PH_WR_BIT);
                else
                    begin_step(PH_WR_ACK);
                return 1'b0;
            end
            PH_WR_ACK:
            begin
                ack_q = ~sda;
                scl_q = 1'b0;
            end
            PH_RD_LO:  begin begin_step(PH_RD_HI); return 1'b0; end
            PH_RD_HI:
            begin
                shifter = {shifter[6:0], sda};
                bits_done = bits_done + 1'b1;
                if (bits_done < BYTE_BITS)
                begin
                    begin_step(PH_RD_LO);
                    return 1'b0;
                end
                rx_q = shifter;
                begin_step(ack_pick ? PH_RA_A : PH_RN_A);
                return 1'b0;
            end
            PH_RA_A:   begin begin_step(PH_RA_B); return 1'b0; end
            PH_RA_B:   begin begin_step(PH_RA_C1); return 1'b0; end
            PH_RA_C1:  begin begin_step(PH_RA_C2); return 1'b0; end
            PH_RA_C2:  begin begin_step(PH_RA_D); return 1'b0; end
            PH_RA_D:   scl_q = 1'b0;
            PH_RN_A:   begin begin_step(PH_RN_B); return 1'b0; end
            PH_RN_B:   begin begin_step(PH_RN_C1); return 1'b0; end
            PH_RN_C1:  begin begin_step(PH_RN_C2); return 1'b0; end
            default:   ;
        endcase
        bus_phase = PH_IDLE;
        step_left = '0;
        sequences_done++;
        return 1'b1;
    endfunction

    // advance the bus model by one tick and return the line state after it
    function automatic result_t predict_lines(input cmd_t c);
        result_t r;
        logic    done;
        done = 1'b0;
        if (bus_phase == PH_IDLE)
        begin
            if (c.cmd_valid)
            begin
                bits_done = '0;
                case (c.operation)
                    OP_START: begin_step(PH_ST_A1);
                    OP_STOP:  begin_step(PH_SP_A);
                    OP_WRITE:
                    begin
                        shifter = c.tx_byte;
                        begin_step(PH_WR_A);
                    end
                    default:
                    begin
                        ack_pick = c.send_ack;
                        shifter = '0;
                        oe_q = 1'b0;
                        begin_step(PH_RD_LO);
                    end
                endcase
            end
        end
        else
        begin
            if (c.cmd_valid)
                commands_dropped++;
            if (step_left != '0)
                step_left = step_left - 1'b1;
            else
                done = end_step(c.sda_in);
        end
        r.scl_level = scl_q;
        r.sda_drive_enable = oe_q;
        r.sda_level = sdo_q;
        r.busy_res = (bus_phase != PH_IDLE);
        r.done_res = done;
        r.rx_byte = rx_q;
        r.ack_seen = ack_q;
        return r;
    endfunction

    function automatic logic slave_level(input line_t l);
        if (l == LINE_RAND)
            return 1'($urandom_range(0, 1));
        return (l == LINE_HIGH);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch at result %0d: %s got %0h want %0h",
                 results_seen, what, got, want);
    endtask

    // compare one result transaction with the oldest pending line state
    task automatic check_line_state(input logic [M_TDATA_WIDTH-1:0] word);
        result_t got;
        result_t want;
        got = word[RES_BITS-1:0];
        results_seen++;
        if (pending_lines.size() == 0)
        begin
            report_mismatch("result with nothing pending", word, 0);
            return;
        end
        want = pending_lines.pop_front();
        if (word[M_TDATA_WIDTH-1:RES_BITS] !== '0)
            report_mismatch("pad bits", word[M_TDATA_WIDTH-1:RES_BITS], 0);
        if (got.scl_level !== want.scl_level)
            report_mismatch("scl_level", got.scl_level, want.scl_level);
        if (got.sda_drive_enable !== want.sda_drive_enable)
            report_mismatch("sda_drive_enable", got.sda_drive_enable, want.sda_drive_enable);
        if (got.sda_level !== want.sda_level)
            report_mismatch("sda_level", got.sda_level, want.sda_level);
        if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", got.busy_res, want.busy_res);
        if (got.done_res !== want.done_res)
            report_mismatch("done_res", got.done_res, want.done_res);
        if (got.rx_byte !== want.rx_byte)
            report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
        if (got.ack_seen !== want.ack_seen)
            report_mismatch("ack_seen", got.ack_seen, want.ack_seen);
    endtask

    // offer one tick on the slave stream, called and returning at a falling edge
    task automatic put_tick(input cmd_t c, input logic typed, input logic [15:0] typed_word);
        int unsigned gap;
        result_t     model_out;
        gap = gaps_on ? $urandom_range(0, 6) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_TDATA_WIDTH - $bits(cmd_t)){1'b0}}, c};
        do @(posedge clk); while (!s_tready);
        model_out = predict_lines(c);
        pending_lines.push_back(typed ? result_t'(typed_word[RES_BITS-1:0]) : model_out);
        ticks_sent++;
        @(negedge clk);
    endtask

    // feed plain ticks until the running sequence is over
    task automatic run_to_idle(input line_t l, input logic chatter);
        cmd_t c;
        while (bus_phase != PH_IDLE)
        begin
            c.cmd_valid = chatter;
            c.operation = op_t'($urandom_range(0, 3));
            c.tx_byte = 8'($urandom);
            c.send_ack = 1'($urandom);
            c.sda_in = slave_level(l);
            put_tick(c, 1'b0, '0);
        end
    endtask

    // write the delay unit once the block has gone quiet
    task automatic set_unit(input int unsigned u);
        s_tvalid <= 1'b0;
        while (pending_lines.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= DELAY_WIDTH'(u);
        @(negedge clk);
        cfg_we <= 1'b0;
        unit_cfg = DELAY_WIDTH'(u);
        cfg_writes++;
    endtask

    // result side with random back-pressure and one long hold-off
    initial
    begin
        int unsigned hold;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            hold = gaps_on ? $urandom_range(0, 6) : 0;
            if (results_seen == PRESSURE_AT)
                hold = PRESSURE_CYCLES;
            if (hold != 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            check_line_state(m_tdata);
            @(negedge clk);
        end
    end

    // watchdog on cycles with no transaction on either stream
    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (rst_n !== 1'b1 || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // stimulus
    initial
    begin
        cmd_t c;
        int   taken;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed commands, the slowest unit without idling
        foreach (dir_plan[i])
        begin
            if (DELAY_WIDTH'(dir_plan[i].unit) != unit_cfg)
                set_unit(dir_plan[i].unit);
            gaps_on = (dir_plan[i].unit < 64);
            c.cmd_valid = dir_plan[i].valid;
            c.operation = dir_plan[i].op;
            c.tx_byte = dir_plan[i].tx;
            c.send_ack = dir_plan[i].ack;
            c.sda_in = slave_level(dir_plan[i].line);
            put_tick(c, dir_plan[i].typed, dir_plan[i].typed_word);
            run_to_idle(dir_plan[i].line, dir_plan[i].chatter);
        end

        // random commands over a few short delay units
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:       set_unit(1);
                1:       set_unit(2);
                2:       set_unit(3);
                default: set_unit($urandom_range(1, 6));
            endcase
            gaps_on = (ph != 1);
            taken = 0;
            while (taken < RANDOM_PER_PHASE)
            begin
                c.operation = op_t'($urandom_range(0, 3));
                c.tx_byte = 8'($urandom);
                c.send_ack = 1'($urandom);
                c.sda_in = 1'($urandom);
                // likely from idle, often on the closing tick, rarely mid-sequence
                if (bus_phase == PH_IDLE)
                    c.cmd_valid = ($urandom_range(0, 9) < 6);
                else if (step_left == '0 && bus_phase inside
                         {PH_ST_B2, PH_SP_C, PH_WR_ACK, PH_RA_D, PH_RN_C2})
                    c.cmd_valid = ($urandom_range(0, 2) == 0);
                else
                    c.cmd_valid = ($urandom_range(0, 19) == 0);
                if (!(c.cmd_valid && bus_phase != PH_IDLE))
                    taken++;
                put_tick(c, 1'b0, '0);
            end
            run_to_idle(LINE_RAND, 1'b0);
        end

        s_tvalid <= 1'b0;
        while (pending_lines.size() != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);

        $display("run covered %0d ticks, %0d finished bus sequences, %0d commands dropped",
                 ticks_sent, sequences_done, commands_dropped);
        $display("delay unit rewritten %0d times, from zero up to 64 ticks; %0d mismatches",
                 cfg_writes, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
